// ===== src/pctt_pkg.sv =====
// shared types and constants for the periodic countdown timer table
// no dependencies; imported by every module of the block except pctt_ram
package pctt_pkg;

    localparam int ID_W        = 16;
    localparam int IVAL_W      = 16;
    localparam int PER_W       = 15;
    localparam int KIND_W      = 2;
    localparam int STAT_W      = 2;
    localparam int DEF_ENTRIES = 16;
    localparam int MAX_RESULTS = 16;
    localparam int NCNT_W      = $clog2(MAX_RESULTS + 1);
    localparam int ENT_W       = ID_W + 2 * PER_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_SET   = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic scan_read;
        logic tick_step;
        logic find_hit;
        logic idx_inc;
        logic resolve;
        logic shift_read;
        logic shift_write;
        logic remove_done;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        kind_t kind;
        logic  idx_end;
        logic  shift_end;
        logic  hit;
        logic  found;
        logic  raw_zero;
        logic  out_free;
        logic  tick_stall;
    } sts_t;

endpackage

// ===== src/pctt_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module pctt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/pctt_ctrl.sv =====
// controller state machine of the timer table: sequences scans, shifts and result beats
// depends on pctt_pkg
module pctt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     kind,
    input  pctt_pkg::sts_t sts,
    output pctt_pkg::cmd_t cmd
);
    import pctt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SCAN_RD  = 6'b000010,
        S_SCAN_CHK = 6'b000100,
        S_RESOLVE  = 6'b001000,
        S_SHIFT_RD = 6'b010000,
        S_SHIFT_WR = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (kind_t'(kind) == KIND_OTHER)
                    begin
                        state_next = S_RESOLVE;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                if (sts.idx_end)
                begin
                    state_next = S_RESOLVE;
                end
                else
                begin
                    cmd.scan_read = 1'b1;
                    state_next    = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (sts.kind == KIND_TICK)
                begin
                    // hold the slot while an earlier fired beat cannot leave
                    if (!sts.tick_stall)
                    begin
                        cmd.tick_step = 1'b1;
                        state_next    = S_SCAN_RD;
                    end
                end
                else if (sts.hit)
                begin
                    cmd.find_hit = 1'b1;
                    state_next   = S_RESOLVE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_RESOLVE:
            begin
                if (sts.kind == KIND_SET && sts.raw_zero && sts.found)
                begin
                    state_next = S_SHIFT_RD;
                end
                else if (sts.out_free)
                begin
                    cmd.resolve = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_SHIFT_RD:
            begin
                if (sts.shift_end)
                begin
                    if (sts.out_free)
                    begin
                        cmd.remove_done = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cmd.shift_read = 1'b1;
                    state_next     = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.shift_write = 1'b1;
                state_next      = S_SHIFT_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE)
        else $error("item taken outside idle");

    a_shift_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_read |=> cmd.shift_write)
        else $error("shift read not followed by its write");

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.resolve || cmd.remove_done) |-> sts.out_free)
        else $error("result beat issued while output register busy");
`endif

endmodule

// ===== src/pctt_dp.sv =====
// datapath of the timer table: item registers, slot ram, counters, pending and output beat
// depends on pctt_pkg and pctt_ram
module pctt_dp #(
    parameter int ENTRIES = pctt_pkg::DEF_ENTRIES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [pctt_pkg::KIND_W-1:0] kind,
    input  logic [pctt_pkg::ID_W-1:0]   object_id,
    input  logic signed [pctt_pkg::IVAL_W-1:0] interval,
    input  pctt_pkg::cmd_t              cmd,
    output pctt_pkg::sts_t              sts,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [pctt_pkg::ID_W-1:0]   object_id_res,
    output logic                        fired,
    output logic [pctt_pkg::STAT_W-1:0] status,
    output logic [pctt_pkg::PER_W-1:0]  interval_read,
    output logic                        last
);
    import pctt_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    // control state
    logic [CW-1:0]     lc_reg, lc_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [NCNT_W-1:0] n_reg, n_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              found_reg, found_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    kind_t             kind_reg, kind_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [IVAL_W-1:0] raw_reg, raw_next;
    logic [PER_W-1:0]  per_found_reg, per_found_next;
    logic [ID_W-1:0]   pend_id_reg, pend_id_next;
    logic [ID_W-1:0]   o_id_reg, o_id_next;
    logic              o_fired_reg, o_fired_next;
    status_t           o_stat_reg, o_stat_next;
    logic [PER_W-1:0]  o_ival_reg, o_ival_next;
    logic              o_last_reg, o_last_next;

    // ram port
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [ENT_W-1:0]  ram_wdata, ram_rdata;

    logic [ID_W-1:0]   ent_obj;
    logic [PER_W-1:0]  ent_per, ent_cd, new_cd, set_per;
    logic              expired, report, out_free, full;
    logic [CW:0]       idx_plus1;

    pctt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ent_obj   = ram_rdata[ENT_W-1 -: ID_W];
    assign ent_per   = ram_rdata[2*PER_W-1 -: PER_W];
    assign ent_cd    = ram_rdata[PER_W-1:0];
    assign expired   = (ent_cd <= PER_W'(1));
    assign new_cd    = expired ? ent_per : (ent_cd - PER_W'(1));
    assign report    = expired && (n_reg < NCNT_W'(MAX_RESULTS));
    assign out_free  = !out_valid_reg || out_ready;
    assign full      = (lc_reg >= CW'(ENTRIES));
    assign idx_plus1 = {1'b0, idx_reg} + (CW + 1)'(1);
    // negative interval counts as one tick
    assign set_per   = raw_reg[IVAL_W-1] ? PER_W'(1) : raw_reg[PER_W-1:0];

    assign sts.kind       = kind_reg;
    assign sts.idx_end    = (idx_reg >= lc_reg);
    assign sts.shift_end  = (idx_plus1 >= {1'b0, lc_reg});
    assign sts.hit        = (ent_obj == id_reg);
    assign sts.found      = found_reg;
    assign sts.raw_zero   = (raw_reg == '0);
    assign sts.out_free   = out_free;
    assign sts.tick_stall = report && pend_valid_reg && !out_free;

    always_comb
    begin
        lc_next         = lc_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        found_next      = found_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        kind_next       = kind_reg;
        id_next         = id_reg;
        raw_next        = raw_reg;
        per_found_next  = per_found_reg;
        pend_id_next    = pend_id_reg;
        o_id_next       = o_id_reg;
        o_fired_next    = o_fired_reg;
        o_stat_next     = o_stat_reg;
        o_ival_next     = o_ival_reg;
        o_last_next     = o_last_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = idx_reg[AW-1:0];
        ram_raddr       = idx_reg[AW-1:0];
        ram_wdata       = {ent_obj, ent_per, new_cd};

        if (cmd.load)
        begin
            kind_next       = kind_t'(kind);
            id_next         = object_id;
            raw_next        = interval;
            idx_next        = '0;
            n_next          = '0;
            pend_valid_next = 1'b0;
            found_next      = 1'b0;
        end

        if (cmd.scan_read)
        begin
            ram_re = 1'b1;
        end

        if (cmd.tick_step)
        begin
            ram_we   = 1'b1;
            idx_next = idx_reg + CW'(1);
            if (report)
            begin
                // the held beat is not the final one, so it leaves with last clear
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    o_id_next      = pend_id_reg;
                    o_fired_next   = 1'b1;
                    o_stat_next    = STAT_OK;
                    o_ival_next    = '0;
                    o_last_next    = 1'b0;
                end
                pend_id_next    = ent_obj;
                pend_valid_next = 1'b1;
                n_next          = n_reg + NCNT_W'(1);
            end
        end

        if (cmd.find_hit)
        begin
            found_next     = 1'b1;
            per_found_next = ent_per;
        end

        if (cmd.idx_inc)
        begin
            idx_next = idx_reg + CW'(1);
        end

        if (cmd.resolve)
        begin
            out_valid_next = 1'b1;
            o_id_next      = id_reg;
            o_fired_next   = 1'b0;
            o_stat_next    = STAT_OK;
            o_ival_next    = '0;
            o_last_next    = 1'b1;
            case (kind_reg)
                KIND_TICK:
                begin
                    o_id_next    = pend_valid_reg ? pend_id_reg : '0;
                    o_fired_next = pend_valid_reg;
                end
                KIND_SET:
                begin
                    if (raw_reg == '0)
                    begin
                        o_stat_next = STAT_NOT_FOUND;
                    end
                    else if (found_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {id_reg, set_per, set_per};
                    end
                    else if (full)
                    begin
                        o_stat_next = STAT_FULL;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = lc_reg[AW-1:0];
                        ram_wdata = {id_reg, set_per, set_per};
                        lc_next   = lc_reg + CW'(1);
                    end
                end
                KIND_QUERY:
                begin
                    o_ival_next = found_reg ? per_found_reg : '0;
                end
                default:
                begin
                    o_stat_next = STAT_OK;
                end
            endcase
        end

        if (cmd.shift_read)
        begin
            ram_re    = 1'b1;
            ram_raddr = idx_plus1[AW-1:0];
        end

        if (cmd.shift_write)
        begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            idx_next  = idx_reg + CW'(1);
        end

        if (cmd.remove_done)
        begin
            lc_next        = lc_reg - CW'(1);
            out_valid_next = 1'b1;
            o_id_next      = id_reg;
            o_fired_next   = 1'b0;
            o_stat_next    = STAT_OK;
            o_ival_next    = '0;
            o_last_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg         <= '0;
            idx_reg        <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            lc_reg         <= lc_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            found_reg      <= found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        id_reg        <= id_next;
        raw_reg       <= raw_next;
        per_found_reg <= per_found_next;
        pend_id_reg   <= pend_id_next;
        o_id_reg      <= o_id_next;
        o_fired_reg   <= o_fired_next;
        o_stat_reg    <= o_stat_next;
        o_ival_reg    <= o_ival_next;
        o_last_reg    <= o_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign object_id_res = o_id_reg;
    assign fired         = o_fired_reg;
    assign status        = o_stat_reg;
    assign interval_read = o_ival_reg;
    assign last          = o_last_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lc_reg <= CW'(ENTRIES))
        else $error("live count beyond table size");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_read |-> idx_plus1 < {1'b0, lc_reg})
        else $error("shift reads past the live entries");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.remove_done |=> lc_reg == $past(lc_reg) - CW'(1))
        else $error("removal did not shrink the table");
`endif

endmodule

// ===== src/periodic_countdown_timer_table.sv =====
// periodic countdown timer table: one item at a time through a shared slot ram
// tick: each live entry is read and written back in turn, held while a fired beat waits
// set and query compare slots in turn up to a hit; removal then moves each later entry down
// next item is taken once the last beat of the current one sits in the output register
// reset clears the live count and control; slot contents are left as they are, no clearing pass
// depends on pctt_pkg, pctt_ctrl, pctt_dp, pctt_ram
module periodic_countdown_timer_table #(
    parameter int ENTRIES = pctt_pkg::DEF_ENTRIES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [pctt_pkg::KIND_W-1:0] kind,
    input  logic [pctt_pkg::ID_W-1:0]   object_id,
    input  logic signed [pctt_pkg::IVAL_W-1:0] interval,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [pctt_pkg::ID_W-1:0]   object_id_res,
    output logic                        fired,
    output logic [pctt_pkg::STAT_W-1:0] status,
    output logic [pctt_pkg::PER_W-1:0]  interval_read,
    output logic                        last
);
    import pctt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    pctt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .sts      (sts),
        .cmd      (cmd)
    );

    pctt_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .kind          (kind),
        .object_id     (object_id),
        .interval      (interval),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .object_id_res (object_id_res),
        .fired         (fired),
        .status        (status),
        .interval_read (interval_read),
        .last          (last)
    );

endmodule
